### hdl/segment_map_range_claim_unit_defines.svh
// Assertion macros shared by the segment map checker
`ifndef SEGMENT_MAP_RANGE_CLAIM_UNIT_DEFINES_SVH
`define SEGMENT_MAP_RANGE_CLAIM_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("segment map check failed");

// next-cycle implication, disabled in reset
`define SMR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("segment map check failed");

`endif

### hdl/smrc_pkg.sv
// Shared constants for the segment map range claim unit
package smrc_pkg;

  localparam int FIELD_W  = 24;
  localparam int TYPE_W   = 6;
  localparam int RIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;
  localparam int KIND_W   = 2;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 72;

  localparam logic [KIND_W-1:0] KIND_CLAIM   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLAIMED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERRUN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

  localparam logic [1:0] SPLIT_HEAD = 2'd0;
  localparam logic [1:0] SPLIT_TAIL = 2'd1;
  localparam logic [1:0] SPLIT_MID  = 2'd2;

  localparam logic [FIELD_W-1:0] REGION_RESET = 24'hFFFFFF;

endpackage

### hdl/segment_map_range_claim_unit.sv
// Segment map range claim unit: ordered segment table in one memory
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | in_tuser kind, in_tdata claim/read fields
//  out_    | out | out_tvalid / out_tready | out_tdata status and segment fields
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data region_length
//
// One item at a time. Restart, zero-length claim and unknown kind answer from idle.
// A read scans the table entry by entry up to its index; a claim scans up to the hit
// segment, then moves the later entries up and writes the two or three parts of the split.
// The single memory port (one read, one write a cycle) sets this order of steps.
// After reset the S_INIT state writes the initial segment; no input is taken before that.
// A result waiting on out_tready blocks the next input transfer.
module segment_map_range_claim_unit
  import smrc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 256,
  parameter int OFFSET_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // offset, length, block_type, is_anim, read_index, zero pad
  input  logic [IN_W-1:0]     in_tdata,
  // kind
  input  logic [KIND_W-1:0]   in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // status, seg_start, seg_length, seg_type, seg_anim, seg_present, segment_count, pad
  output logic [OUT_W-1:0]    out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FIELD_W-1:0]  cfg_data
);

  localparam int OB = OFFSET_BITS;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = OB + TYPE_W + 1;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;

  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rdata_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [2:0]          state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [OB-1:0]       off_r, off_nxt;
  logic [OB-1:0]       len_r, len_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  logic                anim_r, anim_nxt;
  logic [RIDX_W-1:0]   ridx_r, ridx_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       hit_r, hit_nxt;
  logic [OB-1:0]       start_r, start_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [FIELD_W-1:0]  region_r;
  logic [1:0]          mode_r, mode_nxt;
  logic [1:0]          need_r, need_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [OB-1:0]       fix_a_r, fix_a_nxt;
  logic [OB-1:0]       fix_b_r, fix_b_nxt;
  logic                canim_r, canim_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  logic [OB-1:0]       o_start_r, o_start_nxt;
  logic [OB-1:0]       o_len_r, o_len_nxt;
  logic [TYPE_W-1:0]   o_type_r, o_type_nxt;
  logic                o_anim_r, o_anim_nxt;
  logic                o_present_r, o_present_nxt;

  logic [OB-1:0]     rd_len;
  logic [TYPE_W-1:0] rd_type;
  logic              rd_anim;
  logic [OB:0]       seg_end;
  logic [OB:0]       rng_end;
  logic              at_head;
  logic              at_tail;
  logic [1:0]        need_c;
  logic              in_xfer;
  logic [OB-1:0]     in_len;
  logic [OB-1:0]     new_len;

  assign rd_len  = rdata_r[EW-1:TYPE_W+1];
  assign rd_type = rdata_r[TYPE_W:1];
  assign rd_anim = rdata_r[0];
  assign seg_end = {1'b0, start_r} + {1'b0, rd_len};
  assign rng_end = {1'b0, off_r} + {1'b0, len_r};
  assign at_head = (off_r == start_r);
  assign at_tail = (rng_end == seg_end);
  assign need_c  = (at_head && at_tail) ? 2'd0 : ((at_head || at_tail) ? 2'd1 : 2'd2);
  assign in_len  = OB'(in_tdata[2*FIELD_W-1:FIELD_W]);
  assign new_len = OB'(region_r);

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    anim_nxt      = anim_r;
    ridx_nxt      = ridx_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    start_nxt     = start_r;
    total_nxt     = total_r;
    mode_nxt      = mode_r;
    need_nxt      = need_r;
    step_nxt      = step_r;
    fix_a_nxt     = fix_a_r;
    fix_b_nxt     = fix_b_r;
    canim_nxt     = canim_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_start_nxt   = o_start_r;
    o_len_nxt     = o_len_r;
    o_type_nxt    = o_type_r;
    o_anim_nxt    = o_anim_r;
    o_present_nxt = o_present_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_data   = {new_len, {TYPE_W{1'b0}}, 1'b0};
        total_nxt = CW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt      = in_tuser;
          off_nxt       = OB'(in_tdata[FIELD_W-1:0]);
          len_nxt       = in_len;
          type_nxt      = in_tdata[2*FIELD_W+TYPE_W-1:2*FIELD_W];
          anim_nxt      = in_tdata[2*FIELD_W+TYPE_W];
          ridx_nxt      = in_tdata[2*FIELD_W+TYPE_W+RIDX_W:2*FIELD_W+TYPE_W+1];
          idx_nxt       = '0;
          start_nxt     = '0;
          o_status_nxt  = ST_OK;
          o_start_nxt   = '0;
          o_len_nxt     = '0;
          o_type_nxt    = '0;
          o_anim_nxt    = 1'b0;
          o_present_nxt = 1'b0;
          case (in_tuser)
            KIND_CLAIM: begin
              if (in_len == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            KIND_READ: begin
              if (32'(in_tdata[2*FIELD_W+TYPE_W+RIDX_W:2*FIELD_W+TYPE_W+1])
                  < 32'(total_r)) begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            KIND_RESTART: begin
              wr_en         = 1'b1;
              wr_data       = {new_len, {TYPE_W{1'b0}}, 1'b0};
              total_nxt     = CW'(1);
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (kind_r == KIND_READ) begin
          if (32'(idx_r) == 32'(ridx_r)) begin
            o_present_nxt = 1'b1;
            o_start_nxt   = start_r;
            o_len_nxt     = rd_len;
            o_type_nxt    = rd_type;
            o_anim_nxt    = rd_anim;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            start_nxt = OB'(seg_end);
            idx_nxt   = idx_r + IW'(1);
            rd_en     = 1'b1;
            rd_addr   = idx_r + IW'(1);
          end
        end else if ({1'b0, off_r} < seg_end) begin
          hit_nxt   = idx_r;
          canim_nxt = rd_anim;
          need_nxt  = need_c;
          mode_nxt  = at_head ? SPLIT_HEAD : (at_tail ? SPLIT_TAIL : SPLIT_MID);
          fix_a_nxt = at_head || at_tail ? rd_len - len_r : off_r - start_r;
          fix_b_nxt = OB'(seg_end - rng_end);
          if (rd_type != '0) begin
            o_status_nxt  = ST_CLAIMED;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (rng_end > seg_end) begin
            o_status_nxt  = ST_OVERRUN;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (32'(total_r) + 32'(need_c) > 32'(MAX_SEGMENTS)) begin
            o_status_nxt  = ST_TABLE_FULL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (need_c == 2'd0) begin
            wr_en         = 1'b1;
            wr_addr       = idx_r;
            wr_data       = {rd_len, type_r, anim_r};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (32'(total_r) > 32'(idx_r) + 32'd1) begin
            idx_nxt   = IW'(total_r - CW'(1));
            rd_en     = 1'b1;
            rd_addr   = IW'(total_r - CW'(1));
            state_nxt = S_SHIFT;
          end else begin
            step_nxt  = 2'd0;
            state_nxt = S_FIX;
          end
        end else if (32'(idx_r) + 32'd1 == 32'(total_r)) begin
          o_status_nxt  = ST_OUT_RANGE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          start_nxt = OB'(seg_end);
          idx_nxt   = idx_r + IW'(1);
          rd_en     = 1'b1;
          rd_addr   = idx_r + IW'(1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + IW'(need_r);
        wr_data = rdata_r;
        if (idx_r == hit_r + IW'(1)) begin
          step_nxt  = 2'd0;
          state_nxt = S_FIX;
        end else begin
          idx_nxt = idx_r - IW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r - IW'(1);
        end
      end
      S_FIX: begin
        wr_en    = 1'b1;
        wr_addr  = hit_r + IW'(step_r);
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: begin
            if (mode_r == SPLIT_HEAD) begin
              wr_data = {len_r, type_r, anim_r};
            end else begin
              wr_data = {fix_a_r, {TYPE_W{1'b0}}, canim_r};
            end
          end
          2'd1: begin
            if (mode_r == SPLIT_HEAD) begin
              wr_data = {fix_a_r, {TYPE_W{1'b0}}, canim_r};
            end else begin
              wr_data = {len_r, type_r, anim_r};
            end
          end
          default: begin
            wr_data = {fix_b_r, {TYPE_W{1'b0}}, 1'b0};
          end
        endcase
        if (step_r == need_r) begin
          total_nxt     = total_r + CW'(need_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      total_r     <= CW'(1);
      region_r    <= REGION_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        region_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    off_r       <= off_nxt;
    len_r       <= len_nxt;
    type_r      <= type_nxt;
    anim_r      <= anim_nxt;
    ridx_r      <= ridx_nxt;
    idx_r       <= idx_nxt;
    hit_r       <= hit_nxt;
    start_r     <= start_nxt;
    mode_r      <= mode_nxt;
    need_r      <= need_nxt;
    step_r      <= step_nxt;
    fix_a_r     <= fix_a_nxt;
    fix_b_r     <= fix_b_nxt;
    canim_r     <= canim_nxt;
    o_status_r  <= o_status_nxt;
    o_start_r   <= o_start_nxt;
    o_len_r     <= o_len_nxt;
    o_type_r    <= o_type_nxt;
    o_anim_r    <= o_anim_nxt;
    o_present_r <= o_present_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, COUNT_W'(total_r), o_present_r, o_anim_r, o_type_r,
                       FIELD_W'(o_len_r), FIELD_W'(o_start_r), o_status_r};

endmodule

### hdl/smrc_checker.sv
// Port checker for the segment map range claim unit, with its bind
`include "segment_map_range_claim_unit_defines.svh"

module smrc_checker
  import smrc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [STATUS_W-1:0] status;
  logic                present;
  logic [COUNT_W-1:0]  count;

  assign status  = out_tdata[STATUS_W-1:0];
  assign present = out_tdata[2*FIELD_W+TYPE_W+STATUS_W+1];
  assign count   = out_tdata[OUT_W-5:OUT_W-4-COUNT_W];

  `SMR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SMR_ASSERT_IMPLY(a_status_code, clk, rst_n, out_tvalid,
    status == ST_OK || status == ST_CLAIMED || status == ST_OVERRUN ||
    status == ST_OUT_RANGE || status == ST_TABLE_FULL)
  `SMR_ASSERT_IMPLY(a_fail_no_seg, clk, rst_n, out_tvalid && status != ST_OK,
    out_tdata[2*FIELD_W+TYPE_W+STATUS_W+1:STATUS_W] == '0)
  `SMR_ASSERT_IMPLY(a_count_nonzero, clk, rst_n, out_tvalid || present, count != '0)
  `SMR_ASSERT_IMPLY(a_one_in_flight, clk, rst_n, out_tvalid, !in_tready)

endmodule

bind segment_map_range_claim_unit smrc_checker u_smrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
